>>> hdl/ple_pkg.sv
// shared types and constants of the positional list engine
package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DUMP = 1'b1
  } back_state_t;

  typedef struct packed {
    opcode_t                  op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } result_t;

endpackage

>>> hdl/ple_front.sv
// front end: accepts input transfers, drops unused opcodes, queues commands for the back end
module ple_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          in_opcode,
  input  logic [ple_pkg::POS_W-1:0]           in_position,
  input  logic signed [ple_pkg::DATA_W-1:0]   in_value,
  output logic                                cmd_valid,
  output ple_pkg::cmd_t                       cmd,
  input  logic                                cmd_take
);

  ple_pkg::cmd_t cq_r [2];
  logic          cq_wp_r;
  logic          cq_rp_r;
  logic [1:0]    cq_cnt_r;
  logic          accept;
  logic          enq;
  logic          deq;

  // accepted transfer; the unused opcode is dropped here
  assign full   = (cq_cnt_r == 2'd2);
  assign accept = push && !full;
  assign enq    = accept && (ple_pkg::opcode_t'(in_opcode) != ple_pkg::OP_NONE);
  assign deq    = cmd_take && cmd_valid;

  assign cmd_valid = (cq_cnt_r != 2'd0);
  assign cmd       = cq_r[cq_rp_r];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_wp_r  <= 1'b0;
      cq_rp_r  <= 1'b0;
      cq_cnt_r <= 2'd0;
    end else begin
      if (enq) cq_wp_r <= ~cq_wp_r;
      if (deq) cq_rp_r <= ~cq_rp_r;
      unique case ({enq, deq})
        2'b10:   cq_cnt_r <= cq_cnt_r + 2'd1;
        2'b01:   cq_cnt_r <= cq_cnt_r - 2'd1;
        default: cq_cnt_r <= cq_cnt_r;
      endcase
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (enq) begin
      cq_r[cq_wp_r].op    <= ple_pkg::opcode_t'(in_opcode);
      cq_r[cq_wp_r].pos   <= in_position;
      cq_r[cq_wp_r].value <= in_value;
    end
  end

endmodule

>>> hdl/ple_back.sv
// back end: list cell chain, command execution, dump sequencer and result queue
module ple_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  ple_pkg::cmd_t                      cmd,
  output logic                               cmd_take,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         out_status,
  output logic signed [ple_pkg::DATA_W-1:0]  out_element,
  output logic                               out_last
);

  logic signed [ple_pkg::DATA_W-1:0] ent_r   [ple_pkg::CAPACITY];
  logic signed [ple_pkg::DATA_W-1:0] ent_nxt [ple_pkg::CAPACITY];
  logic [ple_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic [ple_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  ple_pkg::back_state_t              state_r, state_nxt;
  logic                              ent_we;

  ple_pkg::result_t                  res;
  logic                              res_we;
  ple_pkg::result_t                  rq_r [2];
  logic                              rq_wp_r;
  logic                              rq_rp_r;
  logic [1:0]                        rq_cnt_r;
  logic                              rq_space;
  logic                              rq_deq;
  logic [ple_pkg::POS_W-1:0]         len_pos;

  assign rq_space = (rq_cnt_r != 2'd2);
  assign rq_deq   = pop && !empty;
  assign len_pos  = ple_pkg::POS_W'(len_r);

  // state, length and dump index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ple_pkg::BK_IDLE;
      len_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // list cells
  always_ff @(posedge clk) begin
    if (ent_we) begin
      for (int i = 0; i < ple_pkg::CAPACITY; i++) ent_r[i] <= ent_nxt[i];
    end
  end

  // execute commands and sequence dumps
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    ent_we    = 1'b0;
    cmd_take  = 1'b0;
    res_we    = 1'b0;
    res       = '{status: ple_pkg::ST_OK, element: '0, last: 1'b1};
    for (int i = 0; i < ple_pkg::CAPACITY; i++) ent_nxt[i] = ent_r[i];

    unique case (state_r)
      ple_pkg::BK_IDLE: begin
        if (cmd_valid && rq_space) begin
          cmd_take = 1'b1;
          res_we   = 1'b1;
          unique case (cmd.op)
            ple_pkg::OP_INSERT: begin
              if (cmd.pos > len_pos) begin
                res.status = ple_pkg::ST_BEYOND;
              end else if (len_r == ple_pkg::LEN_W'(ple_pkg::CAPACITY)) begin
                res.status = ple_pkg::ST_FULL;
              end else begin
                // each cell takes the new value, its upper neighbor or itself
                for (int i = 0; i < ple_pkg::CAPACITY; i++) begin
                  if (ple_pkg::POS_W'(i) == cmd.pos) begin
                    ent_nxt[i] = cmd.value;
                  end else if (ple_pkg::POS_W'(i) > cmd.pos) begin
                    ent_nxt[i] = ent_r[(i + ple_pkg::CAPACITY - 1) % ple_pkg::CAPACITY];
                  end
                end
                ent_we  = 1'b1;
                len_nxt = len_r + 1'b1;
              end
            end
            ple_pkg::OP_DELETE: begin
              if (len_r == '0) begin
                res.status = ple_pkg::ST_EMPTY;
              end else if (cmd.pos >= len_pos) begin
                res.status = ple_pkg::ST_BEYOND;
              end else begin
                // cells from the position on take their lower neighbor
                for (int i = 0; i < ple_pkg::CAPACITY; i++) begin
                  if (ple_pkg::POS_W'(i) >= cmd.pos) begin
                    ent_nxt[i] = ent_r[(i + 1) % ple_pkg::CAPACITY];
                  end
                end
                ent_we  = 1'b1;
                len_nxt = len_r - 1'b1;
              end
            end
            ple_pkg::OP_DUMP: begin
              if (len_r == '0) begin
                res.status = ple_pkg::ST_EMPTY;
              end else begin
                res.element = ent_r[0];
                res.last    = (len_r == ple_pkg::LEN_W'(1));
                if (len_r != ple_pkg::LEN_W'(1)) begin
                  state_nxt = ple_pkg::BK_DUMP;
                  idx_nxt   = ple_pkg::IDX_W'(1);
                end
              end
            end
            default: begin
              res_we = 1'b0;
            end
          endcase
        end
      end
      ple_pkg::BK_DUMP: begin
        if (rq_space) begin
          res_we      = 1'b1;
          res.element = ent_r[idx_r];
          res.last    = ((ple_pkg::LEN_W'(idx_r) + 1'b1) == len_r);
          idx_nxt     = idx_r + 1'b1;
          if (res.last) state_nxt = ple_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = ple_pkg::BK_IDLE;
      end
    endcase
  end

  // result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r  <= 1'b0;
      rq_rp_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      if (res_we) rq_wp_r <= ~rq_wp_r;
      if (rq_deq) rq_rp_r <= ~rq_rp_r;
      unique case ({res_we, rq_deq})
        2'b10:   rq_cnt_r <= rq_cnt_r + 2'd1;
        2'b01:   rq_cnt_r <= rq_cnt_r - 2'd1;
        default: rq_cnt_r <= rq_cnt_r;
      endcase
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (res_we) rq_r[rq_wp_r] <= res;
  end

  assign empty       = (rq_cnt_r == 2'd0);
  assign out_status  = rq_r[rq_rp_r].status;
  assign out_element = rq_r[rq_rp_r].element;
  assign out_last    = rq_r[rq_rp_r].last;

endmodule

>>> hdl/positional_list_engine.sv
// top level of the positional list engine
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values.
// Input channel: a queue write port (push, full) carrying opcode, position
// and value; a transfer happens when push is high and full is low.
// Opcode insert puts the value at a position, delete removes the entry at a
// position, dump streams every entry in order; opcode 3 is dropped silently.
// Result channel: a queue read port (empty, pop); the oldest result sits on
// out_status, out_element and out_last while empty is low, and leaves on pop.
// Insert, delete and any error give one result with out_last set; a dump
// gives one result per entry, out_last on the final one.
// A command's first result passes through the command queue register and then
// the result queue register before it reaches the result ports. Insert and
// delete sustain one command per cycle while the receiver keeps up and no dump
// runs; a dump streams one entry per cycle while the result queue has room.
// A two-entry command queue between front and back end and a two-entry
// result queue decouple the sides; when the receiver stalls, the result
// queue fills, the back end waits and then full rises on the input side.
// Reset (synchronous, rst_n low) empties the list and both queues.
module positional_list_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         in_opcode,
  input  logic [ple_pkg::POS_W-1:0]          in_position,
  input  logic signed [ple_pkg::DATA_W-1:0]  in_value,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         out_status,
  output logic signed [ple_pkg::DATA_W-1:0]  out_element,
  output logic                               out_last
);

  logic          cmd_valid;
  logic          cmd_take;
  ple_pkg::cmd_t cmd;

  // accept and classify
  ple_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_opcode   (in_opcode),
    .in_position (in_position),
    .in_value    (in_value),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  // execute on the list
  ple_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (out_last)
  );

endmodule

>>> hdl/ple_checker.sv
// port-level checks of the positional list engine and their bind
module ple_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               empty,
  input logic                               pop,
  input logic [1:0]                         out_status,
  input logic signed [ple_pkg::DATA_W-1:0]  out_element,
  input logic                               out_last
);

  // no result is pending right after reset
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // error results carry no element
  a_err_no_element: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != 2'(ple_pkg::ST_OK)) |-> (out_element == '0))
    else $error("error result with nonzero element");

  // an error always closes its command's results
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != 2'(ple_pkg::ST_OK)) |-> out_last)
    else $error("error result without last");

  // a stalled result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_element) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .empty       (empty),
  .pop         (pop),
  .out_status  (out_status),
  .out_element (out_element),
  .out_last    (out_last)
);
